/* design/rf_remote_pulse_decoder_assert.svh */
// Assertion macros used by the remote pulse decoder RTL.
`ifndef RF_REMOTE_PULSE_DECODER_ASSERT_SVH
`define RF_REMOTE_PULSE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfpd assertion failed");

`endif

/* design/rfpd_pkg.sv */
// Types, constants and codes of the remote pulse decoder.
`default_nettype none
package rfpd_pkg;

	localparam int FRAME_BITS = 24;
	localparam int WORD_W     = 24;
	localparam int TICK_W     = 16;
	localparam int IDX_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_EDGE = 2'd1,
		OP_POLL = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		KEY_UP   = 2'd0,
		KEY_OK   = 2'd1,
		KEY_DOWN = 2'd2
	} key_code_t;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_UP       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_OK       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_DOWN     = 3'd6;

	typedef struct packed {
		logic [1:0] opcode;
		logic       pin_level;
	} evt_t;

	typedef struct packed {
		logic              frame_valid;
		logic [WORD_W-1:0] frame_word;
		logic              key_valid;
		logic [1:0]        key_code;
	} res_t;

	typedef struct packed {
		logic      hit;
		key_code_t code;
	} key_match_t;

endpackage
`default_nettype wire

/* design/rf_remote_pulse_decoder.sv */
// Top level of the 24-bit pulse-width remote frame decoder.
//
//  channel  direction  payload        handshake
//  evt      in         rfpd_pkg::evt_t evt_valid / evt_stall
//  res      out        rfpd_pkg::res_t res_valid / res_stall
//  cfg      in         cfg_index/data  cfg_we, no wait
//
// Each event passes through the input register and then the result register;
// one event per cycle is sustained while the result is not stalled. The rate
// is set by the single decoder state update done as an event leaves the
// input register. Every event yields exactly one result transfer.
// A stalled result holds; the input register keeps taking events until it
// is full behind a stalled result. Reset clears all decoder state and loads
// the register defaults; there is no clearing pass.
`default_nettype none
`include "rf_remote_pulse_decoder_assert.svh"
module rf_remote_pulse_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              evt_valid,
	output logic                                   evt_stall,
	input  wire rfpd_pkg::evt_t                    evt,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output rfpd_pkg::res_t                         res,
	input  wire logic                              cfg_we,
	input  wire logic [rfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rfpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int TW = rfpd_pkg::TICK_W;
	localparam int WW = rfpd_pkg::WORD_W;
	localparam int IW = rfpd_pkg::IDX_W;

	// Configuration registers
	logic [TW-1:0] sync_min_q, sync_max_q, bit_threshold_q, release_ticks_q;
	logic [WW-1:0] code_up_q, code_ok_q, code_down_q;

	// Decoder state
	logic [TW-1:0] interval_ticks_q, release_count_q;
	logic          receiving_q, frame_ready_q, key_lock_q;
	logic [IW-1:0] bit_index_q;
	logic [WW-1:0] frame_bits_q;

	// Input and result registers
	logic           evt_valid_s1;
	rfpd_pkg::evt_t evt_s1;
	logic           res_valid_q;
	rfpd_pkg::res_t res_q;

	logic advance;

	// Next-state values
	logic [TW-1:0] interval_ticks_d, release_count_d;
	logic          receiving_d, frame_ready_d, key_lock_d;
	logic [IW-1:0] bit_index_d, bit_index_inc;
	logic [WW-1:0] frame_bits_d, bit_mask;
	rfpd_pkg::res_t res_d;
	logic           key_grant;

	rfpd_pkg::key_match_t match;

	// Advance the input register when the result register is free or draining.
	assign advance   = evt_valid_s1 && (!res_valid_q || !res_stall);
	assign evt_stall = evt_valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	rfpd_key_match u_match (
		.word      (frame_bits_q),
		.code_up   (code_up_q),
		.code_ok   (code_ok_q),
		.code_down (code_down_q),
		.match     (match)
	);

	assign bit_index_inc = bit_index_q + 1'b1;
	assign bit_mask      = WW'(1) << bit_index_q;
	assign key_grant     = match.hit && !key_lock_q;

	always_comb begin
		interval_ticks_d = interval_ticks_q;
		release_count_d  = release_count_q;
		receiving_d      = receiving_q;
		frame_ready_d    = frame_ready_q;
		key_lock_d       = key_lock_q;
		bit_index_d      = bit_index_q;
		frame_bits_d     = frame_bits_q;
		res_d            = '0;
		case (evt_s1.opcode)
			rfpd_pkg::OP_TICK: begin
				// Saturate the interval counter; count towards lock release.
				if (interval_ticks_q != {TW{1'b1}}) begin
					interval_ticks_d = interval_ticks_q + 1'b1;
				end
				if (release_count_q >= release_ticks_q) begin
					release_count_d = release_ticks_q;
					key_lock_d      = 1'b0;
				end else begin
					release_count_d = release_count_q + 1'b1;
				end
			end
			rfpd_pkg::OP_EDGE: begin
				// A held frame freezes the receiver until polled.
				if (!frame_ready_q) begin
					interval_ticks_d = '0;
					if (evt_s1.pin_level) begin
						if (!receiving_q) begin
							// Sync window: min inclusive, max exclusive.
							receiving_d  = (interval_ticks_q >= sync_min_q) &&
							               (interval_ticks_q < sync_max_q);
							bit_index_d  = '0;
							frame_bits_d = '0;
						end else begin
							if (32'(bit_index_q) < WW) begin
								if (interval_ticks_q > bit_threshold_q) begin
									frame_bits_d = frame_bits_q | bit_mask;
								end else begin
									frame_bits_d = frame_bits_q & ~bit_mask;
								end
							end
							bit_index_d = bit_index_inc;
							if (bit_index_inc == '0 ||
							    32'(bit_index_inc) >= rfpd_pkg::FRAME_BITS) begin
								frame_ready_d = 1'b1;
								bit_index_d   = '0;
								receiving_d   = 1'b0;
							end
							release_count_d = '0;
						end
					end
				end
			end
			rfpd_pkg::OP_POLL: begin
				// Release the held frame and try it against the key codes.
				if (frame_ready_q) begin
					frame_ready_d     = 1'b0;
					res_d.frame_valid = 1'b1;
					res_d.frame_word  = frame_bits_q;
					if (key_grant) begin
						key_lock_d      = 1'b1;
						res_d.key_valid = 1'b1;
						res_d.key_code  = match.code;
					end
				end
			end
			default: begin
				// Unused opcode: drop, empty result.
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q      <= TW'(110);
			sync_max_q      <= TW'(130);
			bit_threshold_q <= TW'(7);
			release_ticks_q <= TW'(500);
			code_up_q       <= '0;
			code_ok_q       <= '0;
			code_down_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rfpd_pkg::REG_SYNC_MIN:      sync_min_q      <= cfg_data[TW-1:0];
				rfpd_pkg::REG_SYNC_MAX:      sync_max_q      <= cfg_data[TW-1:0];
				rfpd_pkg::REG_BIT_THRESHOLD: bit_threshold_q <= cfg_data[TW-1:0];
				rfpd_pkg::REG_RELEASE_TICKS: release_ticks_q <= cfg_data[TW-1:0];
				rfpd_pkg::REG_CODE_UP:       code_up_q       <= cfg_data[WW-1:0];
				rfpd_pkg::REG_CODE_OK:       code_ok_q       <= cfg_data[WW-1:0];
				rfpd_pkg::REG_CODE_DOWN:     code_down_q     <= cfg_data[WW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold while stalled, otherwise take the next transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall) begin
			evt_s1 <= evt;
		end
	end

	// Decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_ticks_q <= '0;
			release_count_q  <= '0;
			receiving_q      <= 1'b0;
			frame_ready_q    <= 1'b0;
			key_lock_q       <= 1'b0;
			bit_index_q      <= '0;
			frame_bits_q     <= '0;
			res_valid_q      <= 1'b0;
		end else begin
			if (advance) begin
				interval_ticks_q <= interval_ticks_d;
				release_count_q  <= release_count_d;
				receiving_q      <= receiving_d;
				frame_ready_q    <= frame_ready_d;
				key_lock_q       <= key_lock_d;
				bit_index_q      <= bit_index_d;
				frame_bits_q     <= frame_bits_d;
				res_valid_q      <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	`RFPD_ASSERT_NOW(a_stall_needs_item, clk, arst_n, evt_stall, evt_valid_s1)
	`RFPD_ASSERT_NOW(a_held_not_receiving, clk, arst_n, frame_ready_q, !receiving_q)
	`RFPD_ASSERT_NOW(a_index_only_receiving, clk, arst_n, bit_index_q != '0, receiving_q)
	`RFPD_ASSERT_NEXT(a_key_sets_lock, clk, arst_n,
		advance && evt_s1.opcode == rfpd_pkg::OP_POLL && frame_ready_q && key_grant,
		key_lock_q && res_valid_q && res_q.key_valid && res_q.frame_valid)

endmodule
`default_nettype wire

/* design/rfpd_key_match.sv */
// Key code matcher: compares a released frame word with the three key codes.
`default_nettype none
module rfpd_key_match (
	input  wire logic [rfpd_pkg::WORD_W-1:0] word,
	input  wire logic [rfpd_pkg::WORD_W-1:0] code_up,
	input  wire logic [rfpd_pkg::WORD_W-1:0] code_ok,
	input  wire logic [rfpd_pkg::WORD_W-1:0] code_down,
	output rfpd_pkg::key_match_t             match
);

	logic trivial;

	// All-ones and all-zero words never carry a key.
	assign trivial = (word == rfpd_pkg::WORD_ONES) || (word == '0);

	always_comb begin
		match.hit  = 1'b0;
		match.code = rfpd_pkg::KEY_UP;
		if (!trivial) begin
			// Up takes priority over ok, ok over down.
			if (word == code_up) begin
				match.hit  = 1'b1;
				match.code = rfpd_pkg::KEY_UP;
			end else if (word == code_ok) begin
				match.hit  = 1'b1;
				match.code = rfpd_pkg::KEY_OK;
			end else if (word == code_down) begin
				match.hit  = 1'b1;
				match.code = rfpd_pkg::KEY_DOWN;
			end
		end
	end

endmodule
`default_nettype wire
